>>> src/keyframe_curve_evaluator_macros.svh
// Assertion macros for the keyframe curve evaluator.
// Used by the top level only; needs nothing else.
`ifndef KEYFRAME_CURVE_EVALUATOR_MACROS_SVH
`define KEYFRAME_CURVE_EVALUATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KCE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define KCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/kce_pkg.sv
// Shared types and codes for the keyframe curve evaluator.
// Standalone; used by the RAM, the divider and the top level.
package kce_pkg;

  // Default table depth.
  localparam int MAX_KEYS_DEF = 64;

  // Widths of the default RAM instance.
  localparam int RAM_WIDTH_DEF = 32;

  // Item kinds.
  localparam logic [2:0] KIND_WRITE   = 3'd0;
  localparam logic [2:0] KIND_TANGENT = 3'd1;
  localparam logic [2:0] KIND_MODE    = 3'd2;
  localparam logic [2:0] KIND_CLEAR   = 3'd3;
  localparam logic [2:0] KIND_EVAL    = 3'd4;

  // Interpolation modes.
  localparam logic [1:0] MODE_BEZIER  = 2'd0;
  localparam logic [1:0] MODE_LINEAR  = 2'd1;
  localparam logic [1:0] MODE_STEPPED = 2'd2;
  localparam logic [1:0] MODE_AUTO    = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_HELD   = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  // Divider operand width.
  localparam int DIV_W = 33;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] rem_init;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
    logic [5:0]       steps;
  } div_req_t;

endpackage

>>> src/kce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on kce_pkg for default sizes.
module kce_ram #(
  parameter int WIDTH = kce_pkg::RAM_WIDTH_DEF,
  parameter int DEPTH = kce_pkg::MAX_KEYS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/kce_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on kce_pkg for the request struct.
module kce_div (
  input  logic                           clk,
  input  logic                           rst,
  input  kce_pkg::div_req_t              req,
  output logic                           busy,
  output logic [kce_pkg::DIV_W-1:0]      quo
);

  logic [kce_pkg::DIV_W-1:0] rem;
  logic [kce_pkg::DIV_W-1:0] num;
  logic [kce_pkg::DIV_W-1:0] den;
  logic [5:0]                cnt;
  logic [kce_pkg::DIV_W:0]   sh;
  logic [kce_pkg::DIV_W:0]   diff;
  logic                      fits;

  // Shift the next dividend bit into the partial remainder and try the subtract.
  assign sh   = {rem, num[kce_pkg::DIV_W-1]};
  assign diff = sh - {1'b0, den};
  assign fits = (sh >= {1'b0, den});
  assign busy = (cnt != 6'd0);

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
    end else if (req.start) begin
      cnt <= req.steps;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
    end
  end

  // Remainder, dividend and quotient registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      num <= req.num;
      den <= req.den;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? diff[kce_pkg::DIV_W-1:0] : sh[kce_pkg::DIV_W-1:0];
      num <= {num[kce_pkg::DIV_W-2:0], 1'b0};
      quo <= {quo[kce_pkg::DIV_W-2:0], fits};
    end
  end

endmodule

>>> src/kce_mul.sv
// Shared 33 by 32 bit unsigned multiplier with a registered product.
// Standalone; used by the top level sequencer.
module kce_mul (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [31:0] b,
  output logic [64:0] p
);

  // Product is registered before any further use.
  always_ff @(posedge clk) begin
    p <= 65'(a) * 65'(b);
  end

endmodule

>>> src/keyframe_curve_evaluator.sv
// Keyframe curve evaluator: holds up to MAX_KEYS keys (time, Q16.16 value, tangents, mode) and
// evaluates the curve at a query time with stepped, linear or cubic Hermite interpolation. Key
// writes and clears act on acceptance; tangent and mode writes read the entry and write it back
// merged from S_TWR. An evaluation walks the key RAM sequentially for the bracket search, then
// uses the shared one-bit-per-cycle divider for the fraction and any auto tangents and the shared
// multiplier for the Hermite terms. The block takes one item at a time; a finished result waits
// in the output register.
`include "keyframe_curve_evaluator_macros.svh"

module keyframe_curve_evaluator #(
  parameter int MAX_KEYS = kce_pkg::MAX_KEYS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic [5:0]         slot,
  input  logic signed [31:0] key_time,
  input  logic signed [31:0] key_value,
  input  logic signed [31:0] tangent_in,
  input  logic signed [31:0] tangent_out,
  input  logic [2:0]         interp_mode,
  input  logic signed [31:0] query_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] curve_value,
  output logic [1:0]         status
);

  localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = ((KW > 7) ? KW : 7) + 1;
  localparam logic signed [65:0] ACC_MAX = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] ACC_MIN = -66'sh0_8000_0000;

  // Sequencer states.
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_TWR   = 5'd1;
  localparam logic [4:0] S_FIRST = 5'd2;
  localparam logic [4:0] S_WALK  = 5'd3;
  localparam logic [4:0] S_AUXLO = 5'd4;
  localparam logic [4:0] S_AUXHI = 5'd5;
  localparam logic [4:0] S_NEXT  = 5'd6;
  localparam logic [4:0] S_UWAIT = 5'd7;
  localparam logic [4:0] S_A1    = 5'd8;
  localparam logic [4:0] S_A1W   = 5'd9;
  localparam logic [4:0] S_A2    = 5'd10;
  localparam logic [4:0] S_A2W   = 5'd11;
  localparam logic [4:0] S_U2    = 5'd12;
  localparam logic [4:0] S_U3    = 5'd13;
  localparam logic [4:0] S_X1    = 5'd14;
  localparam logic [4:0] S_X2    = 5'd15;
  localparam logic [4:0] S_H     = 5'd16;
  localparam logic [4:0] S_TSEL  = 5'd17;
  localparam logic [4:0] S_TLO   = 5'd18;
  localparam logic [4:0] S_THI   = 5'd19;
  localparam logic [4:0] S_TACC  = 5'd20;
  localparam logic [4:0] S_FIN   = 5'd21;
  localparam logic [4:0] S_OUT   = 5'd22;

  // Control state.
  logic [4:0]          state;
  logic [4:0]          state_next;
  logic [6:0]          key_count;
  logic [MAX_KEYS-1:0] vld;

  // Item and walk registers.
  logic [CW-1:0]       idx;
  logic [CW-1:0]       idx_next;
  logic [CW-1:0]       lo;
  logic [CW-1:0]       hi;
  logic [CW-1:0]       n;
  logic                slot_ok;
  logic                op_tan;
  logic [1:0]          mode_l;
  logic signed [31:0]  tin_l;
  logic signed [31:0]  tout_l;
  logic signed [31:0]  qt;
  logic signed [31:0]  t_lo, v_lo, t_hi, v_hi, t_prev, v_prev, t_next, v_next;
  logic signed [32:0]  dt;
  logic [1:0]          mode;
  logic signed [31:0]  m_out, m_in;
  logic                dneg;
  logic [31:0]         u, u2, u3;
  logic signed [63:0]  x1, x2;
  logic signed [35:0]  h01, h10, h11;
  logic [1:0]          tsel;
  logic [32:0]         hmag;
  logic [63:0]         xmag;
  logic                tneg;
  logic [32:0]         lo_part;
  logic signed [65:0]  acc;
  logic signed [31:0]  res_value;
  logic [1:0]          res_status;

  // RAM ports.
  logic                key_we;
  logic [63:0]         key_rdata;
  logic [65:0]         aux_rdata;
  logic [65:0]         aux_wdata;
  logic                aux_we;
  logic signed [31:0]  kd_t, kd_v;
  logic                vld_rd;
  logic signed [31:0]  cur_tin, cur_tout;
  logic [1:0]          cur_mode;

  // Shared units.
  kce_pkg::div_req_t   div_req;
  logic                div_busy;
  logic [32:0]         div_quo;
  logic [32:0]         mul_a;
  logic [31:0]         mul_b;
  logic [64:0]         mul_p;

  // Datapath helpers.
  logic signed [32:0]  dv, dv1, dv2, span1, span2, qoff, wdt;
  logic signed [35:0]  th;
  logic signed [63:0]  tx;
  logic [31:0]         mout_abs, min_abs;
  logic [65:0]         term_m;

  // Saturate a signed quotient given as magnitude and sign to 32 bits.
  function automatic logic signed [31:0] sat_div(input logic [32:0] q, input logic neg);
    logic signed [33:0] s;
    s = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (s > 34'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -34'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign n = (CW'(key_count) > CW'(MAX_KEYS)) ? CW'(MAX_KEYS) : CW'(key_count);
  assign slot_ok = (CW'(slot) < CW'(MAX_KEYS));

  assign kd_t   = $signed(key_rdata[63:32]);
  assign kd_v   = $signed(key_rdata[31:0]);
  assign vld_rd = vld[idx[KW-1:0]];

  // Tangents and mode of the entry at idx; cleared entries read as zero and bezier.
  assign cur_tin  = vld_rd ? $signed(aux_rdata[65:34]) : 32'sd0;
  assign cur_tout = vld_rd ? $signed(aux_rdata[33:2]) : 32'sd0;
  assign cur_mode = vld_rd ? aux_rdata[1:0] : kce_pkg::MODE_BEZIER;

  // Differences used by the interpolation and the auto tangents.
  assign dv    = $signed({v_hi[31], v_hi}) - $signed({v_lo[31], v_lo});
  assign dv1   = $signed({v_hi[31], v_hi}) - $signed({v_prev[31], v_prev});
  assign span1 = $signed({t_hi[31], t_hi}) - $signed({t_prev[31], t_prev});
  assign dv2   = $signed({v_next[31], v_next}) - $signed({v_lo[31], v_lo});
  assign span2 = $signed({t_next[31], t_next}) - $signed({t_lo[31], t_lo});
  assign qoff  = $signed({qt[31], qt}) - $signed({t_lo[31], t_lo});
  assign wdt   = $signed({kd_t[31], kd_t}) - $signed({t_lo[31], t_lo});
  assign mout_abs = m_out[31] ? (~m_out + 32'd1) : m_out;
  assign min_abs  = m_in[31] ? (~m_in + 32'd1) : m_in;
  assign term_m   = {1'b0, mul_p} + {33'd0, lo_part};

  // Tangent or mode write merges the new fields into the current entry.
  always_comb begin
    if (op_tan) begin
      aux_wdata = {tin_l, tout_l,
                   ((cur_mode == kce_pkg::MODE_LINEAR) || (cur_mode == kce_pkg::MODE_STEPPED))
                   ? kce_pkg::MODE_BEZIER : cur_mode};
    end else begin
      aux_wdata = {cur_tin, cur_tout, mode_l};
    end
  end

  // Operands of the current Hermite or linear term.
  always_comb begin
    case (tsel)
      2'd0: begin
        th = h01;
        tx = 64'(dv);
      end
      2'd1: begin
        th = h10;
        tx = x1;
      end
      2'd2: begin
        th = h11;
        tx = x2;
      end
      default: begin
        th = $signed({4'd0, u});
        tx = 64'(dv);
      end
    endcase
  end

  // Sequencer next state, RAM address and shared-unit requests.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    key_we     = 1'b0;
    aux_we     = 1'b0;
    div_req    = '0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (kind == kce_pkg::KIND_EVAL) begin
            if (n == '0) begin
              state_next = S_OUT;
            end else begin
              idx_next   = '0;
              state_next = S_FIRST;
            end
          end else if (kind == kce_pkg::KIND_WRITE) begin
            key_we = slot_ok;
          end else if (slot_ok && ((kind == kce_pkg::KIND_TANGENT) ||
                                   ((kind == kce_pkg::KIND_MODE) && !interp_mode[2]))) begin
            idx_next   = CW'(slot);
            state_next = S_TWR;
          end
        end
      end
      S_TWR: begin
        aux_we     = 1'b1;
        state_next = S_IDLE;
      end
      S_FIRST: begin
        if ((n == CW'(1)) || (qt <= kd_t)) begin
          state_next = S_OUT;
        end else begin
          idx_next   = CW'(1);
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (kd_t <= qt) begin
          if ((idx + CW'(1)) < n) begin
            idx_next = idx + CW'(1);
          end else begin
            state_next = S_OUT;
          end
        end else begin
          // Bracket found: the spacing is positive here, start the fraction division.
          div_req.start    = 1'b1;
          div_req.rem_init = qoff;
          div_req.num      = '0;
          div_req.den      = wdt;
          div_req.steps    = 6'd32;
          idx_next         = lo;
          state_next       = S_AUXLO;
        end
      end
      S_AUXLO: begin
        idx_next   = hi;
        state_next = S_AUXHI;
      end
      S_AUXHI: begin
        idx_next   = ((hi + CW'(1)) < n) ? (hi + CW'(1)) : hi;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        state_next = S_UWAIT;
      end
      S_UWAIT: begin
        if (!div_busy) begin
          case (mode)
            kce_pkg::MODE_STEPPED: state_next = S_OUT;
            kce_pkg::MODE_LINEAR:  state_next = S_TSEL;
            kce_pkg::MODE_AUTO:    state_next = S_A1;
            default:               state_next = S_U2;
          endcase
        end
      end
      S_A1: begin
        if (span1 > 33'sd0) begin
          div_req.start = 1'b1;
          div_req.num   = dv1[32] ? 33'(-dv1) : 33'(dv1);
          div_req.den   = span1;
          div_req.steps = 6'd33;
          state_next    = S_A1W;
        end else begin
          state_next = S_A2;
        end
      end
      S_A1W: begin
        if (!div_busy) begin
          state_next = S_A2;
        end
      end
      S_A2: begin
        if (span2 > 33'sd0) begin
          div_req.start = 1'b1;
          div_req.num   = dv2[32] ? 33'(-dv2) : 33'(dv2);
          div_req.den   = span2;
          div_req.steps = 6'd33;
          state_next    = S_A2W;
        end else begin
          state_next = S_U2;
        end
      end
      S_A2W: begin
        if (!div_busy) begin
          state_next = S_U2;
        end
      end
      S_U2: begin
        mul_a      = {1'b0, u};
        mul_b      = u;
        state_next = S_U3;
      end
      S_U3: begin
        mul_a      = {1'b0, mul_p[63:32]};
        mul_b      = u;
        state_next = S_X1;
      end
      S_X1: begin
        mul_a      = dt;
        mul_b      = mout_abs;
        state_next = S_X2;
      end
      S_X2: begin
        mul_a      = dt;
        mul_b      = min_abs;
        state_next = S_H;
      end
      S_H: begin
        state_next = S_TSEL;
      end
      S_TSEL: begin
        state_next = S_TLO;
      end
      S_TLO: begin
        mul_a      = hmag;
        mul_b      = xmag[31:0];
        state_next = S_THI;
      end
      S_THI: begin
        mul_a      = hmag;
        mul_b      = xmag[63:32];
        state_next = S_TACC;
      end
      S_TACC: begin
        state_next = ((tsel == 2'd2) || (tsel == 2'd3)) ? S_FIN : S_TSEL;
      end
      S_FIN: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers: state, key count, entry valid bits, output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_count <= 7'd0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        key_count <= cfg_data;
      end
      if ((state == S_IDLE) && in_valid && (kind == kce_pkg::KIND_CLEAR)) begin
        vld <= '0;
      end else if (state == S_TWR) begin
        vld[idx[KW-1:0]] <= 1'b1;
      end
      if ((state == S_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    idx <= idx_next;
    case (state)
      S_IDLE: begin
        qt         <= query_time;
        tin_l      <= tangent_in;
        tout_l     <= tangent_out;
        mode_l     <= interp_mode[1:0];
        op_tan     <= (kind == kce_pkg::KIND_TANGENT);
        res_value  <= 32'sd0;
        res_status <= kce_pkg::ST_EMPTY;
      end
      S_FIRST: begin
        t_lo       <= kd_t;
        v_lo       <= kd_v;
        t_prev     <= kd_t;
        v_prev     <= kd_v;
        lo         <= '0;
        res_value  <= kd_v;
        res_status <= kce_pkg::ST_HELD;
      end
      S_WALK: begin
        if (kd_t <= qt) begin
          t_prev    <= t_lo;
          v_prev    <= v_lo;
          t_lo      <= kd_t;
          v_lo      <= kd_v;
          lo        <= idx;
          res_value <= kd_v;
        end else begin
          t_hi <= kd_t;
          v_hi <= kd_v;
          hi   <= idx;
          dt   <= wdt;
        end
      end
      S_AUXLO: begin
        mode  <= cur_mode;
        m_out <= cur_tout;
      end
      S_AUXHI: begin
        m_in <= cur_tin;
      end
      S_NEXT: begin
        t_next <= kd_t;
        v_next <= kd_v;
      end
      S_UWAIT: begin
        u          <= div_quo[31:0];
        res_value  <= v_lo;
        res_status <= kce_pkg::ST_INTERP;
        tsel       <= 2'd3;
        acc        <= 66'(v_lo);
      end
      S_A1: begin
        dneg <= dv1[32];
        if (span1 <= 33'sd0) begin
          m_out <= 32'sd0;
        end
      end
      S_A1W: begin
        if (!div_busy) begin
          m_out <= sat_div(div_quo, dneg);
        end
      end
      S_A2: begin
        dneg <= dv2[32];
        if (span2 <= 33'sd0) begin
          m_in <= 32'sd0;
        end
      end
      S_A2W: begin
        if (!div_busy) begin
          m_in <= sat_div(div_quo, dneg);
        end
      end
      S_U3: begin
        u2 <= mul_p[63:32];
      end
      S_X1: begin
        u3 <= mul_p[63:32];
      end
      S_X2: begin
        x1 <= m_out[31] ? -$signed(mul_p[63:0]) : $signed(mul_p[63:0]);
      end
      S_H: begin
        // Hermite basis weights in Q0.32.
        x2   <= m_in[31] ? -$signed(mul_p[63:0]) : $signed(mul_p[63:0]);
        h01  <= $signed({3'd0, u2, 1'b0}) + $signed({4'd0, u2}) - $signed({3'd0, u3, 1'b0});
        h10  <= $signed({4'd0, u3}) - $signed({3'd0, u2, 1'b0}) + $signed({4'd0, u});
        h11  <= $signed({4'd0, u3}) - $signed({4'd0, u2});
        tsel <= 2'd0;
        acc  <= 66'(v_lo);
      end
      S_TSEL: begin
        hmag <= th[35] ? 33'(-th) : 33'(th);
        xmag <= tx[63] ? 64'(-tx) : 64'(tx);
        tneg <= th[35] ^ tx[63];
      end
      S_THI: begin
        lo_part <= mul_p[64:32];
      end
      S_TACC: begin
        acc  <= tneg ? (acc - $signed(term_m)) : (acc + $signed(term_m));
        tsel <= tsel + 2'd1;
      end
      S_FIN: begin
        if (mode == kce_pkg::MODE_LINEAR) begin
          res_value <= acc[31:0];
        end else if (acc > ACC_MAX) begin
          res_value  <= 32'sh7FFF_FFFF;
          res_status <= kce_pkg::ST_SAT;
        end else if (acc < ACC_MIN) begin
          res_value  <= 32'sh8000_0000;
          res_status <= kce_pkg::ST_SAT;
        end else begin
          res_value <= acc[31:0];
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          curve_value <= res_value;
          status      <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  // Key times and values.
  kce_ram #(
    .WIDTH(64),
    .DEPTH(MAX_KEYS)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(KW'(slot)),
    .wdata({key_time, key_value}),
    .raddr(idx_next[KW-1:0]),
    .rdata(key_rdata)
  );

  // Tangents and mode per key.
  kce_ram #(
    .WIDTH(66),
    .DEPTH(MAX_KEYS)
  ) u_aux_ram (
    .clk  (clk),
    .we   (aux_we),
    .waddr(idx[KW-1:0]),
    .wdata(aux_wdata),
    .raddr(idx_next[KW-1:0]),
    .rdata(aux_rdata)
  );

  kce_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .busy(div_busy),
    .quo (div_quo)
  );

  kce_mul u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  // An evaluation never completes in the cycle it is accepted.
  `KCE_ASSERT_NEXT(a_eval_busy, clk, rst, in_valid && in_ready && (kind == kce_pkg::KIND_EVAL), !in_ready, "evaluation accepted without sequencing")
  // The divider is never restarted while it is still working.
  `KCE_ASSERT_IMPL(a_div_idle, clk, rst, div_req.start, !div_busy, "divider restarted while busy")
  // A saturated result is one of the two clamp values.
  `KCE_ASSERT_IMPL(a_sat_value, clk, rst, out_valid && (status == kce_pkg::ST_SAT), (curve_value == 32'sh7FFF_FFFF) || (curve_value == 32'sh8000_0000), "saturated status with unclamped value")
  // An empty table always yields zero.
  `KCE_ASSERT_IMPL(a_empty_zero, clk, rst, out_valid && (status == kce_pkg::ST_EMPTY), curve_value == 32'sd0, "empty status with nonzero value")

endmodule
